// ===== design/dtks_pkg.sv =====
// ----------------------------------------------------------------------------
// dtks_pkg
// Shared types, codes and BCD helpers for the BCD date/time key setter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtks_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_NEXT = 2'd1,
    MODE_INC  = 2'd2,
    MODE_DEC  = 2'd3
  } mode_t;

  localparam logic [2:0] FIELD_YEAR    = 3'd0;
  localparam logic [2:0] FIELD_MONTH   = 3'd1;
  localparam logic [2:0] FIELD_DAY     = 3'd2;
  localparam logic [2:0] FIELD_HOUR    = 3'd3;
  localparam logic [2:0] FIELD_MINUTE  = 3'd4;
  localparam logic [2:0] FIELD_SECOND  = 3'd5;
  localparam logic [2:0] FIELD_CONFIRM = 3'd6;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] load_year;
    logic [4:0] load_month;
    logic [5:0] load_day;
    logic [5:0] load_hour;
    logic [6:0] load_minute;
    logic [6:0] load_second;
  } in_t;

  typedef struct packed {
    logic [2:0] selected_field;
    logic [7:0] year_out;
    logic [4:0] month_out;
    logic [5:0] day_out;
    logic [5:0] hour_out;
    logic [6:0] minute_out;
    logic [6:0] second_out;
    logic       apply_strobe;
  } out_t;

  localparam out_t RESET_STATE = '{
    selected_field: FIELD_YEAR,
    year_out:       8'h16,
    month_out:      5'h04,
    day_out:        6'h30,
    hour_out:       6'h00,
    minute_out:     7'h00,
    second_out:     7'h00,
    apply_strobe:   1'b0
  };

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // tens * 10 + units, nibbles at face value
  function automatic logic [7:0] bcd_val(input logic [7:0] v);
    logic [7:0] tens;
    logic [7:0] units;
    tens  = {4'd0, v[7:4]};
    units = {4'd0, v[3:0]};
    return (tens << 3) + (tens << 1) + units;
  endfunction

  // binary 0..99 to two bcd digits, divide by ten via reciprocal
  function automatic logic [7:0] bin_to_bcd(input logic [6:0] d);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  units;
    prod     = {8'd0, d} * 15'd205;
    tens     = prod[14:11];
    tens_x10 = ({3'd0, tens} << 3) + ({3'd0, tens} << 1);
    units    = d - tens_x10;
    return {tens, units[3:0]};
  endfunction

  // days in month for year 2000 + yy, 31 for an out-of-range month
  function automatic logic [4:0] days_in(input logic [7:0] yy, input logic [7:0] mm);
    logic       leap;
    logic [3:0] idx;
    logic [4:0] len;
    leap = (yy[1:0] == 2'd0) && (yy != 8'd100);
    idx  = mm[3:0] - 4'd1;
    if (mm < 8'd1 || mm > 8'd12) begin
      len = 5'd31;
    end else if (mm == 8'd2 && leap) begin
      len = 5'd29;
    end else begin
      len = MONTH_LEN[idx];
    end
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/bcd_date_time_key_setter_top.sv =====
// a request passes through the input register and then the result register
// throughput: one request per cycle while out_stall is low, the input and result registers stall together
// the result register holds the date/time state, so each result follows the one before
// reset (synchronous, active low) empties both registers, selects year and
// sets the time to 16-04-30 00:00:00 in bcd
// ----------------------------------------------------------------------------
// bcd_date_time_key_setter_top
// Key-driven setter for a bcd date and time with a load request.
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_date_time_key_setter_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dtks_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dtks_pkg::out_t      out_data
);

  logic           req_valid;
  logic           req_take;
  dtks_pkg::in_t  req_data;
  dtks_pkg::out_t state_nxt;

  dtks_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .req_take  (req_take),
    .req_valid (req_valid),
    .req_data  (req_data)
  );

  dtks_update u_upd (
    .req (req_data),
    .cur (out_data),
    .nxt (state_nxt)
  );

  dtks_result_stage u_res (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_take  (req_take),
    .state_nxt (state_nxt),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/dtks_in_stage.sv =====
// ----------------------------------------------------------------------------
// dtks_in_stage
// Input register for key requests; holds a request until the result side moves.
// ----------------------------------------------------------------------------
`default_nettype none

module dtks_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire dtks_pkg::in_t in_data,
  input  wire logic          req_take,
  output logic               req_valid,
  output dtks_pkg::in_t      req_data
);

  logic          valid_r;
  logic          valid_nxt;
  dtks_pkg::in_t data_r;

  assign in_stall  = valid_r && !req_take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  assign req_valid = valid_r;
  assign req_data  = data_r;

endmodule

`default_nettype wire

// ===== design/dtks_update.sv =====
// ----------------------------------------------------------------------------
// dtks_update
// Next-state logic: load, field select, per-field bcd adjust and the apply strobe on confirm.
// ----------------------------------------------------------------------------
`default_nettype none

module dtks_update (
  input  wire dtks_pkg::in_t  req,
  input  wire dtks_pkg::out_t cur,
  output dtks_pkg::out_t      nxt
);

  logic signed [9:0] delta_s;
  logic signed [9:0] year_v;
  logic signed [9:0] month_v;
  logic signed [9:0] day_v;
  logic signed [9:0] hour_v;
  logic signed [9:0] minute_v;
  logic signed [9:0] second_v;
  logic signed [9:0] maxd_s;
  logic [6:0]        year_c;
  logic [6:0]        month_c;
  logic [6:0]        day_c;
  logic [6:0]        hour_c;
  logic [6:0]        minute_c;
  logic [6:0]        second_c;
  logic [7:0]        year_b;
  logic [7:0]        month_b;
  logic [7:0]        day_b;
  logic [7:0]        hour_b;
  logic [7:0]        minute_b;
  logic [7:0]        second_b;

  assign delta_s = (req.mode == dtks_pkg::MODE_INC) ? 10'sd1 : -10'sd1;

  assign year_v   = $signed({2'b00, dtks_pkg::bcd_val(cur.year_out)}) + delta_s;
  assign month_v  = $signed({2'b00, dtks_pkg::bcd_val({3'd0, cur.month_out})}) + delta_s;
  assign day_v    = $signed({2'b00, dtks_pkg::bcd_val({2'd0, cur.day_out})}) + delta_s;
  assign hour_v   = $signed({2'b00, dtks_pkg::bcd_val({2'd0, cur.hour_out})}) + delta_s;
  assign minute_v = $signed({2'b00, dtks_pkg::bcd_val({1'd0, cur.minute_out})}) + delta_s;
  assign second_v = $signed({2'b00, dtks_pkg::bcd_val({1'd0, cur.second_out})}) + delta_s;

  assign maxd_s = $signed({5'd0, dtks_pkg::days_in(dtks_pkg::bcd_val(cur.year_out),
                                                   dtks_pkg::bcd_val({3'd0, cur.month_out}))});

  always_comb begin
    // year saturates 0..99
    if (year_v < 10'sd0) begin
      year_c = 7'd0;
    end else if (year_v > 10'sd99) begin
      year_c = 7'd99;
    end else begin
      year_c = year_v[6:0];
    end
    // month wraps 1..12
    if (month_v < 10'sd1) begin
      month_c = 7'd12;
    end else if (month_v > 10'sd12) begin
      month_c = 7'd1;
    end else begin
      month_c = month_v[6:0];
    end
    // day saturates 1..month length
    if (day_v < 10'sd1) begin
      day_c = 7'd1;
    end else if (day_v > maxd_s) begin
      day_c = maxd_s[6:0];
    end else begin
      day_c = day_v[6:0];
    end
    if (hour_v < 10'sd0) begin
      hour_c = 7'd23;
    end else if (hour_v > 10'sd23) begin
      hour_c = 7'd0;
    end else begin
      hour_c = hour_v[6:0];
    end
    if (minute_v < 10'sd0) begin
      minute_c = 7'd59;
    end else if (minute_v > 10'sd59) begin
      minute_c = 7'd0;
    end else begin
      minute_c = minute_v[6:0];
    end
    if (second_v < 10'sd0) begin
      second_c = 7'd59;
    end else if (second_v > 10'sd59) begin
      second_c = 7'd0;
    end else begin
      second_c = second_v[6:0];
    end
  end

  assign year_b   = dtks_pkg::bin_to_bcd(year_c);
  assign month_b  = dtks_pkg::bin_to_bcd(month_c);
  assign day_b    = dtks_pkg::bin_to_bcd(day_c);
  assign hour_b   = dtks_pkg::bin_to_bcd(hour_c);
  assign minute_b = dtks_pkg::bin_to_bcd(minute_c);
  assign second_b = dtks_pkg::bin_to_bcd(second_c);

  always_comb begin
    nxt              = cur;
    nxt.apply_strobe = 1'b0;
    unique case (req.mode)
      dtks_pkg::MODE_LOAD: begin
        nxt.year_out   = req.load_year;
        nxt.month_out  = req.load_month;
        nxt.day_out    = req.load_day;
        nxt.hour_out   = req.load_hour;
        nxt.minute_out = req.load_minute;
        nxt.second_out = req.load_second;
      end
      dtks_pkg::MODE_NEXT: begin
        nxt.selected_field = (cur.selected_field < dtks_pkg::FIELD_CONFIRM) ?
                             cur.selected_field + 3'd1 : dtks_pkg::FIELD_YEAR;
      end
      default: begin
        case (cur.selected_field)
          dtks_pkg::FIELD_YEAR:   nxt.year_out   = year_b;
          dtks_pkg::FIELD_MONTH:  nxt.month_out  = month_b[4:0];
          dtks_pkg::FIELD_DAY:    nxt.day_out    = day_b[5:0];
          dtks_pkg::FIELD_HOUR:   nxt.hour_out   = hour_b[5:0];
          dtks_pkg::FIELD_MINUTE: nxt.minute_out = minute_b[6:0];
          dtks_pkg::FIELD_SECOND: nxt.second_out = second_b[6:0];
          default:                nxt.apply_strobe = 1'b1;
        endcase
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/dtks_result_stage.sv =====
// ----------------------------------------------------------------------------
// dtks_result_stage
// Result register; it also holds the selection and the six time values.
// ----------------------------------------------------------------------------
`default_nettype none

module dtks_result_stage (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           req_valid,
  output logic                req_take,
  input  wire dtks_pkg::out_t state_nxt,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dtks_pkg::out_t      out_data
);

  logic           valid_r;
  logic           valid_nxt;
  dtks_pkg::out_t state_r;

  assign req_take  = req_valid && !(valid_r && out_stall);
  assign valid_nxt = req_take ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      state_r <= dtks_pkg::RESET_STATE;
    end else begin
      valid_r <= valid_nxt;
      if (req_take) begin
        state_r <= state_nxt;
      end
    end
  end

  assign out_valid = valid_r;
  assign out_data  = state_r;

endmodule

`default_nettype wire

// ===== design/dtks_checker.sv =====
// ----------------------------------------------------------------------------
// dtks_checker
// Port-level checks for the key setter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtks_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire dtks_pkg::in_t  in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire dtks_pkg::out_t out_data
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled request changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // strobe only while confirm is selected
  a_strobe_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.apply_strobe |->
      out_data.selected_field == dtks_pkg::FIELD_CONFIRM)
    else $error("apply strobe outside confirm");

  // the selection never leaves the range year to confirm
  a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.selected_field <= dtks_pkg::FIELD_CONFIRM)
    else $error("selection out of range");

endmodule

bind bcd_date_time_key_setter_top dtks_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
